/* design/fpa_pkg.sv */
// Shared types and opcodes for the fixed-point ALU.
// No dependencies.
package fpa_pkg;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_INC = 4'd4;
  localparam logic [3:0] OP_DEC = 4'd5;
  localparam logic [3:0] OP_MIN = 4'd6;
  localparam logic [3:0] OP_MAX = 4'd7;
  localparam logic [3:0] OP_I2F = 4'd8;
  localparam logic [3:0] OP_F2I = 4'd9;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               a_less;
    logic               a_greater;
    logic               a_equal;
    logic               divide_by_zero;
  } res_t;

  // Per-item sideband carried alongside the multiplier and divider.
  typedef struct packed {
    logic [3:0]  action;
    logic        neg;
    logic        dz;
    logic        less;
    logic        greater;
    logic        equal;
    logic [31:0] value;
  } side_t;

endpackage

/* design/fpa_front.sv */
// Front stage: decode, compare flags, simple results and operand magnitudes.
// Depends on fpa_pkg.
module fpa_front #(
  parameter int FRAC_BITS = 8,
  parameter int NW = 40
) (
  input  logic             clk,
  input  logic             en,
  input  fpa_pkg::cmd_t    cmd,
  output fpa_pkg::side_t   side,
  output logic [31:0]      mag_a,
  output logic [31:0]      mag_b,
  output logic [NW-1:0]    dividend
);
  import fpa_pkg::*;

  logic [31:0] a, b, ma, mb, val;
  logic        lt, gt;
  side_t       side_next;

  always_comb begin
    a  = cmd.operand_a;
    b  = cmd.operand_b;
    lt = $signed(a) < $signed(b);
    gt = $signed(a) > $signed(b);
    ma = a[31] ? (32'd0 - a) : a;
    mb = b[31] ? (32'd0 - b) : b;
    case (cmd.action)
      OP_ADD:  val = a + b;
      OP_SUB:  val = a - b;
      OP_INC:  val = a + 32'd1;
      OP_DEC:  val = a - 32'd1;
      OP_MIN:  val = lt ? a : b;
      OP_MAX:  val = gt ? a : b;
      OP_I2F:  val = a << FRAC_BITS;
      OP_F2I:  val = 32'($signed(a) >>> FRAC_BITS);
      default: val = 32'd0;
    endcase
    side_next.action  = cmd.action;
    side_next.neg     = a[31] ^ b[31];
    side_next.dz      = (cmd.action == OP_DIV) && (b == 32'd0);
    side_next.less    = lt;
    side_next.greater = gt;
    side_next.equal   = (a == b);
    side_next.value   = val;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side     <= side_next;
      mag_a    <= ma;
      mag_b    <= mb;
      dividend <= NW'(ma) << FRAC_BITS;
    end
  end

endmodule

/* design/fpa_mul.sv */
// Registered unsigned magnitude multiplier in two stages (32x16 partial
// products, then sum and scaling) with a delay line to match the divider
// latency. Depends on fpa_pkg.
module fpa_mul #(
  parameter int FRAC_BITS = 8,
  parameter int NW = 40
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mag_a,
  input  logic [31:0] mag_b,
  output logic [31:0] prod
);
  import fpa_pkg::*;

  logic [47:0] pp_lo, pp_hi;
  logic [63:0] full;
  logic [31:0] dly [NW-1];

  assign full = 64'(pp_lo) + (64'(pp_hi) << 16);

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo  <= 48'(mag_a) * 48'(mag_b[15:0]);
      pp_hi  <= 48'(mag_a) * 48'(mag_b[31:16]);
      dly[0] <= 32'(full >> FRAC_BITS);
      for (int k = 1; k < NW - 1; k++) begin
        dly[k] <= dly[k-1];
      end
    end
  end

  assign prod = dly[NW-2];

endmodule

/* design/fpa_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on fpa_pkg.
module fpa_div #(
  parameter int NW = 40
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic [31:0]   quotient
);
  import fpa_pkg::*;

  logic [31:0]   rem [NW+1];
  logic [NW-1:0] qn  [NW+1];
  logic [31:0]   dv  [NW+1];

  assign rem[0] = 32'd0;
  assign qn[0]  = dividend;
  assign dv[0]  = divisor;

  for (genvar s = 0; s < NW; s++) begin : g_step
    logic [32:0] sh;
    logic [33:0] diff;
    logic        ge;
    always_comb begin
      sh   = {rem[s], qn[s][NW-1]};
      diff = {1'b0, sh} - {2'b00, dv[s]};
      ge   = !diff[33];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? diff[31:0] : sh[31:0];
        qn[s+1]  <= {qn[s][NW-2:0], ge};
        dv[s+1]  <= dv[s];
      end
    end
  end

  assign quotient = qn[NW][31:0];

endmodule

/* design/fixed_point_alu.sv */
// Signed 32-bit fixed-point ALU, top level.
// Depends on fpa_pkg, fpa_front, fpa_mul and fpa_div.
//
// Accepts one operation per cycle while cmd_stall is low. The front stage loads
// at the transfer edge, then one divider stage per quotient bit of the
// 32+FRAC_BITS bit dividend and the output register follow; the multiplier
// spends two of those stages and a delay line on the rest. All operations
// pass through the same number of registers. The whole pipeline holds while a
// result waits under stall.
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  fpa_pkg::cmd_t  cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output fpa_pkg::res_t  res
);
  import fpa_pkg::*;

  localparam int NW = 32 + FRAC_BITS;

  logic        en;
  logic        fv;
  logic [NW-1:0] vd;
  side_t       fside;
  side_t       sd [NW];
  logic [31:0] mag_a, mag_b, prod, quot, mul_r, div_r;
  logic [NW-1:0] dividend;
  res_t        res_next;

  assign en        = !res_valid || !res_stall;
  assign cmd_stall = !en;

  fpa_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
    .clk(clk), .en(en), .cmd(cmd), .side(fside),
    .mag_a(mag_a), .mag_b(mag_b), .dividend(dividend)
  );

  fpa_mul #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_mul (
    .clk(clk), .en(en), .mag_a(mag_a), .mag_b(mag_b), .prod(prod)
  );

  fpa_div #(.NW(NW)) u_div (
    .clk(clk), .en(en), .dividend(dividend), .divisor(mag_b), .quotient(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fv        <= 1'b0;
      vd        <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      fv        <= cmd_valid;
      vd        <= {vd[NW-2:0], fv};
      res_valid <= vd[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= fside;
      for (int k = 1; k < NW; k++) begin
        sd[k] <= sd[k-1];
      end
      res <= res_next;
    end
  end

  always_comb begin
    mul_r = sd[NW-1].neg ? (32'd0 - prod) : prod;
    div_r = sd[NW-1].neg ? (32'd0 - quot) : quot;
    res_next.a_less         = sd[NW-1].less;
    res_next.a_greater      = sd[NW-1].greater;
    res_next.a_equal        = sd[NW-1].equal;
    res_next.divide_by_zero = sd[NW-1].dz;
    case (sd[NW-1].action)
      OP_MUL:  res_next.result_value = mul_r;
      OP_DIV:  res_next.result_value = sd[NW-1].dz ? 32'd0 : div_r;
      default: res_next.result_value = sd[NW-1].value;
    endcase
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.divide_by_zero |-> res.result_value == 32'd0)
    else $error("divide by zero with nonzero result");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot({res.a_less, res.a_greater, res.a_equal}))
    else $error("comparison flags not one-hot");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid && !fv)
    else $error("valid after reset");

endmodule
